// File: rtl/core/i2a_pkg.sv
// shared types, constants and character helpers of the integer to ascii formatter
package i2a_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 64;
  localparam int unsigned DEC_BITS        = 32;
  localparam int unsigned BCD_DIGITS      = 10;
  localparam int unsigned BCD_W           = BCD_DIGITS * 4;
  localparam int unsigned CNT_W           = $clog2(DEC_BITS);
  localparam int unsigned LEN_W           = 5;
  localparam int unsigned KIND_W          = 3;
  localparam int unsigned CHAR_W          = 8;
  localparam int unsigned PRE_IDX_W       = 3;
  localparam int unsigned DIG_W_DEF       = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_SDEC = 3'd0,
    KIND_UDEC = 3'd1,
    KIND_HEXL = 3'd2,
    KIND_HEXU = 3'd3,
    KIND_PTR  = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    PRE_NONE,
    PRE_MINUS,
    PRE_HEX,
    PRE_NIL
  } pre_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_RUN
  } top_state_e;

  typedef enum logic [1:0] {
    E_IDLE,
    E_PREFIX,
    E_SKIP,
    E_DIGIT
  } emit_state_e;

  // control handed from the front end to the character emitter
  typedef struct packed {
    logic             upper;
    pre_sel_e         pre;
    logic [LEN_W-1:0] ndig;
  } job_t;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_X     = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [CHAR_W-1:0] CH_N     = 8'h6e;
  localparam logic [CHAR_W-1:0] CH_I     = 8'h69;
  localparam logic [CHAR_W-1:0] CH_L     = 8'h6c;
  localparam logic [CHAR_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [CHAR_W-1:0] CH_A_LO  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP  = 8'h41;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + CHAR_W'(d);
    end else begin
      return base + CHAR_W'(d - 4'd10);
    end
  endfunction

  function automatic logic [PRE_IDX_W-1:0] prefix_last(input pre_sel_e pre);
    case (pre)
      PRE_HEX: return 3'd1;
      PRE_NIL: return 3'd4;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [CHAR_W-1:0] prefix_char(input pre_sel_e pre,
                                                    input logic [PRE_IDX_W-1:0] idx);
    logic [CHAR_W-1:0] c;
    c = CH_MINUS;
    case (pre)
      PRE_HEX: c = (idx == 3'd0) ? CH_ZERO : CH_X;
      PRE_NIL: begin
        case (idx)
          3'd0:    c = CH_LPAR;
          3'd1:    c = CH_N;
          3'd2:    c = CH_I;
          3'd3:    c = CH_L;
          default: c = CH_RPAR;
        endcase
      end
      default: c = CH_MINUS;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/i2a_dabble.sv
// bit-serial binary to bcd converter, shift-and-add-3, one input bit per cycle
module i2a_dabble
  import i2a_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [DEC_BITS-1:0] bin_i,
  output logic                done_o,
  output logic [BCD_W-1:0]    bcd_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [DEC_BITS-1:0] bin_q, bin_d;
  logic [BCD_W-1:0]    bcd_q, bcd_d;
  logic [BCD_W-1:0]    adj;

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < BCD_DIGITS; i++) begin
      adj[i*4 +: 4] = (bcd_q[i*4 +: 4] >= 4'd5) ? bcd_q[i*4 +: 4] + 4'd3 : bcd_q[i*4 +: 4];
    end
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    bin_d  = bin_q;
    bcd_d  = bcd_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bin_d  = bin_i;
      bcd_d  = '0;
    end else if (busy_q) begin
      bcd_d = {adj[BCD_W-2:0], bin_q[DEC_BITS-1]};
      bin_d = bin_q << 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(DEC_BITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bin_q <= bin_d;
    bcd_q <= bcd_d;
  end

  assign done_o = done_q;
  assign bcd_o  = bcd_q;

endmodule

// File: rtl/core/i2a_emit.sv
// character emitter: prefix text, leading zero skip and one digit per cycle unless the output stalls
module i2a_emit
  import i2a_pkg::*;
#(
  parameter int unsigned DIG_W = DIG_W_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  job_t              job_i,
  input  logic [DIG_W-1:0]  digits_i,
  output logic              busy_o,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,  // char_code
  output logic              m_axis_tlast,
  output logic [LEN_W-1:0]  m_axis_tuser   // total_length
);

  emit_state_e          state_q, state_d;
  logic [DIG_W-1:0]     dig_q;
  logic [LEN_W-1:0]     left_q, len_q;
  logic [PRE_IDX_W-1:0] idx_q;
  pre_sel_e             pre_q;
  logic                 upper_q;

  logic                 m_valid_q;
  logic [CHAR_W-1:0]    m_data_q;
  logic                 m_last_q;
  logic [LEN_W-1:0]     m_len_q;

  logic                 adv;
  logic [3:0]           top_dig;
  logic                 emit_c, last_c, shift_c;
  logic [CHAR_W-1:0]    char_c;

  assign adv     = !m_valid_q || m_axis_tready;
  assign top_dig = dig_q[DIG_W-1 -: 4];

  always_comb begin
    state_d = state_q;
    case (state_q)
      E_IDLE: begin
        if (load_i) begin
          state_d = (job_i.pre == PRE_NONE) ? E_SKIP : E_PREFIX;
        end
      end
      E_PREFIX: begin
        if (adv && idx_q == prefix_last(pre_q)) begin
          state_d = (pre_q == PRE_NIL) ? E_IDLE : E_SKIP;
        end
      end
      E_SKIP: begin
        if (!(top_dig == 4'd0 && left_q > LEN_W'(1))) begin
          state_d = E_DIGIT;
        end
      end
      E_DIGIT: begin
        if (adv && left_q == LEN_W'(1)) begin
          state_d = E_IDLE;
        end
      end
      default: state_d = E_IDLE;
    endcase
  end

  always_comb begin
    emit_c  = 1'b0;
    last_c  = 1'b0;
    shift_c = 1'b0;
    char_c  = CH_ZERO;
    case (state_q)
      E_PREFIX: begin
        emit_c = adv;
        char_c = prefix_char(pre_q, idx_q);
        last_c = (pre_q == PRE_NIL) && (idx_q == prefix_last(pre_q));
      end
      E_SKIP: begin
        shift_c = (top_dig == 4'd0) && (left_q > LEN_W'(1));
      end
      E_DIGIT: begin
        emit_c  = adv;
        shift_c = adv;
        char_c  = hex_char(top_dig, upper_q);
        last_c  = (left_q == LEN_W'(1));
      end
      default: begin
        emit_c = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= E_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit_c) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && state_q == E_IDLE) begin
      dig_q   <= digits_i;
      left_q  <= job_i.ndig;
      len_q   <= '0;
      idx_q   <= '0;
      pre_q   <= job_i.pre;
      upper_q <= job_i.upper;
    end else begin
      if (shift_c) begin
        dig_q  <= dig_q << 4;
        left_q <= left_q - 1'b1;
      end
      if (emit_c) begin
        len_q <= len_q + 1'b1;
        if (state_q == E_PREFIX) begin
          idx_q <= idx_q + 1'b1;
        end
      end
    end
    if (emit_c) begin
      m_data_q <= char_c;
      m_last_q <= last_c;
      m_len_q  <= last_c ? len_q + 1'b1 : '0;
    end
  end

  assign busy_o        = (state_q != E_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_len_q;

endmodule

// File: rtl/core/integer_to_ascii_formatter.sv
// top level of the integer to ascii formatter
//
// Takes one value per transaction with a kind in tuser (0 signed decimal of
// the low 32 bits, 1 unsigned decimal, 2 and 3 lower and upper case hex, 4
// pointer as "0x" plus hex or "(nil)" for zero) and streams its text out one
// character per output transaction, most significant character first; the
// final character has tlast set and carries the character count in tuser.
// Kinds 5 to 7 produce no output and leave the input ready. A decimal value
// first passes through a bit-serial shift-and-add-3 converter, which shifts in
// the 32 bits of the magnitude and then flags completion. The emitter then
// sends any minus sign, skips leading zero digits, changes over to emitting
// and sends the remaining digits. Hex kinds go straight to the emitter, which
// skips leading zero nibbles and emits the rest, after "0x" for a pointer;
// "(nil)" is sent alone. After the last character the block returns to idle.
// The emitter's single output register sets the pace of one character per
// cycle, and output back-pressure stretches it. A new value is taken once the
// emitter has handed its last character to the output register, even while
// that character still waits to be taken.
module integer_to_ascii_formatter
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [63:0]       s_axis_tdata,  // value
  input  logic [KIND_W-1:0] s_axis_tuser,  // kind
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [CHAR_W-1:0] m_axis_tdata,  // char_code
  output logic              m_axis_tlast,
  output logic [LEN_W-1:0]  m_axis_tuser   // total_length
);

  // nibbles of the hex view, and a digit register wide enough for both views
  localparam int unsigned NIB   = (VALUE_WIDTH + 3) / 4;
  localparam int unsigned DNIB  = (NIB > BCD_DIGITS) ? NIB : BCD_DIGITS;
  localparam int unsigned DIG_W = DNIB * 4;

  top_state_e state_q, state_d;
  logic       neg_q;

  logic                s_accept;
  kind_e               kind;
  logic [DEC_BITS-1:0] low;
  logic [DEC_BITS-1:0] mag;
  logic                neg;
  logic                is_dec, is_hex;
  logic [NIB*4-1:0]    hex_ext;
  logic                ptr_zero;

  logic                dab_start;
  logic                dab_done;
  logic [BCD_W-1:0]    dab_bcd;

  logic                emit_load;
  logic                emit_busy;
  job_t                job;
  logic [DIG_W-1:0]    digits;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign kind     = kind_e'(s_axis_tuser);

  // decimal front end: magnitude of the low word, sign noted for the prefix
  assign low = s_axis_tdata[DEC_BITS-1:0];
  assign neg = (kind == KIND_SDEC) && low[DEC_BITS-1];
  assign mag = neg ? (~low + 1'b1) : low;

  // hex front end: only the low VALUE_WIDTH bits count
  assign hex_ext  = (NIB*4)'(s_axis_tdata[VALUE_WIDTH-1:0]);
  assign ptr_zero = (hex_ext == '0);

  always_comb begin
    is_dec = 1'b0;
    is_hex = 1'b0;
    case (kind)
      KIND_SDEC, KIND_UDEC:           is_dec = 1'b1;
      KIND_HEXL, KIND_HEXU, KIND_PTR: is_hex = 1'b1;
      default: begin
        is_dec = 1'b0;
        is_hex = 1'b0;
      end
    endcase
  end

  // sequencing: convert (decimal only), then run the emitter to completion
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept && is_dec) begin
          state_d = ST_CONV;
        end else if (s_accept && is_hex) begin
          state_d = ST_RUN;
        end
      end
      ST_CONV: begin
        if (dab_done) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!emit_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    dab_start     = 1'b0;
    emit_load     = 1'b0;
    job.upper     = 1'b0;
    job.pre       = PRE_NONE;
    job.ndig      = LEN_W'(BCD_DIGITS);
    digits        = DIG_W'(dab_bcd) << (DIG_W - BCD_W);
    case (state_q)
      ST_IDLE: begin
        dab_start = s_accept && is_dec;
        emit_load = s_accept && is_hex;
        job.upper = (kind == KIND_HEXU);
        job.ndig  = LEN_W'(NIB);
        digits    = DIG_W'(hex_ext) << (DIG_W - NIB*4);
        if (kind == KIND_PTR) begin
          job.pre = ptr_zero ? PRE_NIL : PRE_HEX;
        end
      end
      ST_CONV: begin
        emit_load = dab_done;
        job.pre   = neg_q ? PRE_MINUS : PRE_NONE;
      end
      default: begin
        emit_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sign of the value under conversion
  always_ff @(posedge clk_i) begin
    if (dab_start) begin
      neg_q <= neg;
    end
  end

  i2a_dabble u_dabble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dab_start),
    .bin_i   (mag),
    .done_o  (dab_done),
    .bcd_o   (dab_bcd)
  );

  i2a_emit #(
    .DIG_W (DIG_W)
  ) u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (emit_load),
    .job_i         (job),
    .digits_i      (digits),
    .busy_o        (emit_busy),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef SYNTHESIS
  // the converter only finishes while a decimal value is waiting for it
  a_done_in_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dab_done |-> state_q == ST_CONV)
    else $error("bcd conversion finished outside the conversion phase");

  // a value that produces text blocks the input on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && (is_dec || is_hex) |=> !s_axis_tready)
    else $error("input still ready after taking a value");

  // the emitter is only loaded while it is idle
  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_load |-> !emit_busy)
    else $error("emitter loaded while busy");

  // the count rides on the last character only
  a_len_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser != '0)))
    else $error("character count does not match the last flag");
`endif

endmodule

// File: dv/i2a_text_checker.sv
`timescale 1ns / 100ps
// checker for the integer to ascii formatter: predicts the text of each value and compares it
module i2a_text_checker
  import i2a_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_tvalid_i,
  input  logic              in_tready_i,
  input  logic [63:0]       in_tdata_i,   // value
  input  logic [KIND_W-1:0] in_tuser_i,   // kind
  input  logic              out_tvalid_i,
  input  logic              out_tready_i,
  input  logic [CHAR_W-1:0] out_tdata_i,  // char_code
  input  logic              out_tlast_i,
  input  logic [LEN_W-1:0]  out_tuser_i,  // total_length
  output int                mismatch_count_o,
  output int                pending_count_o
);

  localparam int unsigned       REPORT_LIMIT  = 10;
  localparam logic [63:0]       WIDE_MASK     = {64{1'b1}} >> (64 - VALUE_WIDTH);
  localparam logic [CHAR_W-1:0] ASCII_ZERO    = "0";
  localparam logic [CHAR_W-1:0] ASCII_MINUS   = "-";
  localparam logic [CHAR_W-1:0] ASCII_X       = "x";
  localparam logic [CHAR_W-1:0] ASCII_LOWER_A = "a";
  localparam logic [CHAR_W-1:0] ASCII_UPPER_A = "A";
  localparam logic [5*8-1:0]    NIL_TEXT      = "(nil)";

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic [LEN_W-1:0]  total;
  } char_result_t;

  char_result_t pending_chars[$];
  int           mismatches = 0;

  // text of one value, queued a character at a time; digits are gathered least
  // significant first and appended in reverse after any prefix
  function automatic void predict_text(input logic [KIND_W-1:0] kind,
                                       input logic [63:0]       value);
    logic [CHAR_W-1:0] text [0:17];
    logic [CHAR_W-1:0] digits [0:15];
    logic [CHAR_W-1:0] alpha;
    logic [63:0]       wide;
    logic [31:0]       mag;
    logic [3:0]        nib;
    int                len;
    int                n;
    int                i;
    char_result_t      item;
    len  = 0;
    n    = 0;
    wide = value & WIDE_MASK;
    mag  = value[31:0];
    case (kind)
      KIND_SDEC, KIND_UDEC: begin
        if (kind == KIND_SDEC && mag[31]) begin
          text[0] = ASCII_MINUS;
          len = 1;
          mag = -mag;  // the most negative value wraps to its own magnitude
        end
        digits[0] = ASCII_ZERO + CHAR_W'(mag % 10);
        mag = mag / 10;
        n = 1;
        while (mag != 0) begin
          digits[n] = ASCII_ZERO + CHAR_W'(mag % 10);
          mag = mag / 10;
          n = n + 1;
        end
      end
      KIND_HEXL, KIND_HEXU, KIND_PTR: begin
        alpha = (kind == KIND_HEXU) ? ASCII_UPPER_A : ASCII_LOWER_A;
        if (kind == KIND_PTR && wide == '0) begin
          for (i = 0; i < 5; i++) text[i] = NIL_TEXT[8*(4-i) +: 8];
          len = 5;
        end else begin
          if (kind == KIND_PTR) begin
            text[0] = ASCII_ZERO;
            text[1] = ASCII_X;
            len = 2;
          end
          n = 1;
          for (i = 1; i < 16; i++) begin
            if (wide[4*i +: 4] != 4'd0) n = i + 1;
          end
          for (i = 0; i < n; i++) begin
            nib = wide[4*i +: 4];
            digits[i] = (nib < 4'd10) ? ASCII_ZERO + CHAR_W'(nib)
                                      : alpha + CHAR_W'(nib - 4'd10);
          end
        end
      end
      default: len = 0;  // spare kinds give no text
    endcase
    for (i = n - 1; i >= 0; i--) begin
      text[len] = digits[i];
      len = len + 1;
    end
    for (i = 0; i < len; i++) begin
      item.code  = text[i];
      item.last  = (i == len - 1);
      item.total = (i == len - 1) ? LEN_W'(len) : '0;
      pending_chars.push_back(item);
    end
  endfunction

  // a character leaving at the same edge as a new value belongs to an older one
  always @(posedge clk_i) begin : compare
    char_result_t got;
    char_result_t want;
    if (rst_ni) begin
      if (out_tvalid_i && out_tready_i) begin
        got.code  = out_tdata_i;
        got.last  = out_tlast_i;
        got.total = out_tuser_i;
        if (pending_chars.size() == 0) begin
          if (mismatches < REPORT_LIMIT)
            $display("%0t: unexpected character %h last %0b length %0d", $time,
                     got.code, got.last, got.total);
          mismatches++;
        end else begin
          want = pending_chars.pop_front();
          if (got.code !== want.code || got.last !== want.last || got.total !== want.total)
          begin
            if (mismatches < REPORT_LIMIT)
              $display("%0t: expected %h last %0b length %0d, got %h last %0b length %0d",
                       $time, want.code, want.last, want.total,
                       got.code, got.last, got.total);
            mismatches++;
          end
        end
      end
      if (in_tvalid_i && in_tready_i) predict_text(in_tuser_i, in_tdata_i);
    end
    mismatch_count_o <= mismatches;
    pending_count_o  <= pending_chars.size();
  end

endmodule

// File: dv/integer_to_ascii_formatter_tb.sv
`timescale 1ns / 100ps
// testbench top: drives values into the formatter, paces its text stream and gives the verdict
module integer_to_ascii_formatter_tb;
  import i2a_pkg::*;

  // quiet cycles allowed: far above the hold-off plus a full decimal conversion
  localparam int unsigned WATCHDOG_CYCLES = 2000;
  // long receiver hold-off, taken once after this many characters
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned HOLD_OFF_AFTER  = 300;
  // settle time after the last expected character, above the longest latency
  localparam int unsigned DRAIN_CYCLES    = 120;
  localparam int unsigned RANDOM_VALUES   = 160;

  // kinds the block ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  localparam logic [63:0] ALL_ONES = {64{1'b1}};

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [63:0]       s_axis_tdata;   // value
  logic [KIND_W-1:0] s_axis_tuser;   // kind
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [CHAR_W-1:0] m_axis_tdata;   // char_code
  logic              m_axis_tlast;
  logic [LEN_W-1:0]  m_axis_tuser;   // total_length

  int   mismatch_total;
  int   chars_pending;
  logic send_burst = 1'b0;

  integer_to_ascii_formatter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  i2a_text_checker checker_i (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_tvalid_i      (s_axis_tvalid),
    .in_tready_i      (s_axis_tready),
    .in_tdata_i       (s_axis_tdata),
    .in_tuser_i       (s_axis_tuser),
    .out_tvalid_i     (m_axis_tvalid),
    .out_tready_i     (m_axis_tready),
    .out_tdata_i      (m_axis_tdata),
    .out_tlast_i      (m_axis_tlast),
    .out_tuser_i      (m_axis_tuser),
    .mismatch_count_o (mismatch_total),
    .pending_count_o  (chars_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // one value transaction: an idle gap, then tvalid held until tready is seen at an
  // edge; with no gap tvalid simply stays high into the next transaction
  task automatic send_value(input logic [KIND_W-1:0] kind, input logic [63:0] value);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) send_burst = !send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    s_axis_tuser  <= kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int unsigned       formatted;
    int                spare;
    logic [63:0]       raw;
    logic [63:0]       value;
    logic [KIND_W-1:0] kind;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    rst_ni        = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // signed decimal: zero, most negative, most positive with junk above, minus one, 42
    send_value(KIND_SDEC, 64'h0);
    send_value(KIND_SDEC, 64'h0000_0000_8000_0000);
    send_value(KIND_SDEC, 64'hFFFF_FFFF_7FFF_FFFF);
    send_value(KIND_SDEC, 64'h1234_5678_FFFF_FFFF);
    send_value(KIND_SDEC, 64'h0000_0000_0000_002A);
    // unsigned decimal: zero low word under set upper bits, ten digits, one digit
    send_value(KIND_UDEC, 64'hFFFF_FFFF_0000_0000);
    send_value(KIND_UDEC, 64'h0000_0000_FFFF_FFFF);
    send_value(KIND_UDEC, 64'hA5A5_A5A5_8000_0000);
    send_value(KIND_UDEC, 64'h0000_0000_0000_0009);
    // hex: zero, full width, leading zero nibbles
    send_value(KIND_HEXL, 64'h0);
    send_value(KIND_HEXL, ALL_ONES);
    send_value(KIND_HEXL, 64'h0000_0000_0000_00F0);
    send_value(KIND_HEXU, 64'hFEDC_BA98_7654_3210);
    send_value(KIND_HEXU, 64'h0000_0000_00AB_CDEF);
    send_value(KIND_HEXU, 64'h0000_0000_0000_0001);
    // pointer: nil, smallest, full width, top bit only, leading zero nibbles
    send_value(KIND_PTR, 64'h0);
    send_value(KIND_PTR, 64'h0000_0000_0000_0001);
    send_value(KIND_PTR, ALL_ONES);
    send_value(KIND_PTR, 64'h8000_0000_0000_0000);
    send_value(KIND_PTR, 64'h0000_7FFF_DEAD_BEEF);
    // spare kinds are swallowed without text
    for (spare = KIND_SPARE_FIRST; spare <= KIND_SPARE_LAST; spare++)
      send_value(KIND_W'(spare), {$urandom, $urandom});

    // random part: mostly real kinds, values shaped for every text length
    formatted = 0;
    while (formatted < RANDOM_VALUES) begin
      raw = {$urandom, $urandom};
      case ($urandom_range(0, 3))
        0: value = raw;
        1: value = raw >> $urandom_range(1, 63);
        2: value = 64'($urandom_range(0, 1000));
        default: value = {raw[63:32], ~raw[31], 29'h0, raw[1:0]};  // near the sign boundary
      endcase
      if ($urandom_range(0, 19) < 18) begin
        kind = KIND_W'($urandom_range(KIND_SDEC, KIND_PTR));
        formatted++;
      end else begin
        kind = KIND_W'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      end
      send_value(kind, value);
    end
    s_axis_tvalid <= 1'b0;

    // an edge lets the checker register the final transaction before draining
    @(posedge clk_i);
    while (chars_pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0 && chars_pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // character sink: random stalls per transaction, bursts of full rate, and one long
  // hold-off so that the output register and then the input side back up
  initial begin : text_sink
    int unsigned gap;
    int unsigned taken;
    logic        burst;
    m_axis_tready = 1'b0;
    burst         = 1'b0;
    taken         = 0;
    wait (rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) burst = !burst;
      if (taken == HOLD_OFF_AFTER) begin
        gap = HOLD_OFF_CYCLES;
      end else begin
        gap = burst ? 0 : $urandom_range(0, 12);
      end
      if (gap != 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      taken++;
    end
  end

  // watchdog: ends the run after too many cycles without any transaction
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni);
    while (quiet < WATCHDOG_CYCLES) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/i2a_pkg.sv
rtl/core/i2a_dabble.sv
rtl/core/i2a_emit.sv
rtl/core/integer_to_ascii_formatter.sv
dv/i2a_text_checker.sv
dv/integer_to_ascii_formatter_tb.sv
